/* rtl/core/mst_pkg.sv */
// Package for the multi-shape tone oscillator.
// Holds the wave shape codes, the register indexes and the quarter-wave sine entry function.
// No dependencies.
package mst_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WAVE_SHAPE   = 2'd0;
    localparam logic [1:0] CFG_PHASE_STEP   = 2'd1;
    localparam logic [1:0] CFG_PHASE_OFFSET = 2'd2;
    localparam logic [1:0] CFG_GAIN         = 2'd3;

    // Wave shape codes.
    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd1;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd2;
    localparam logic [1:0] SHAPE_SAWTOOTH = 2'd3;

    // Register widths fixed by the programming model.
    localparam int SHAPE_W  = 2;
    localparam int STEP_W   = 31;
    localparam int OFFSET_W = 32;
    localparam int GAIN_W   = 15;
    localparam int CFG_W    = 32;

    // Q1.15 wave values.
    localparam int WAVE_W = 16;
    localparam int SINE_W = 15;
    localparam logic signed [WAVE_W-1:0] WAVE_FULL = 16'sd32767;

    // pi/2 in Q30 and the Taylor series divisors (2n)(2n+1).
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned TAYLOR_DIV [1:7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

    // One entry of the quarter-wave table: round(32767 * sin(pi/2 * k / 2^tb)),
    // evaluated with a Q30 integer Taylor series. Used at elaboration only.
    function automatic logic [SINE_W-1:0] sine_entry(int unsigned k, int unsigned tb);
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        longint          v;
        theta = (HALF_PI_Q30 * longint'(k)) >> tb;
        t2    = (theta * theta) >> 30;
        term  = theta;
        sum   = longint'(theta);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * t2) >> 30) / TAYLOR_DIV[n];
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (v > 32767) begin
            v = 32767;
        end
        return SINE_W'(v);
    endfunction

endpackage

/* rtl/core/mst_sine_rom.sv */
// Quarter-wave sine table with a registered read port.
// Entries are built at elaboration by mst_pkg::sine_entry; depends on mst_pkg.
module mst_sine_rom
    import mst_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [TABLE_BITS:0]   i_addr,
    output logic [SINE_W-1:0]     o_data
);

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    logic [SINE_W-1:0] w_table [DEPTH];
    logic [SINE_W-1:0] r_data;

    // Constant table contents, one entry per quarter-wave index.
    for (genvar k = 0; k < DEPTH; k++) begin : g_entry
        localparam logic [SINE_W-1:0] ENTRY = sine_entry(k, TABLE_BITS);
        assign w_table[k] = ENTRY;
    end

    // Registered read, held while the pipeline is stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_table[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

/* rtl/core/multi_shape_tone_oscillator.sv */
// Multi-shape tone oscillator: phase accumulator, wave shaping, gain scaling.
// Depends on mst_pkg and mst_sine_rom.
//
//  channel  | direction | handshake              | contents
//  ---------+-----------+------------------------+--------------------------------
//  s stream | in        | i_s_tvalid/o_s_tready  | tdata[0] note_start
//  m stream | out       | o_m_tvalid/i_m_tready  | tdata[SAMPLE_BITS-1:0] sample_out
//  cfg      | in        | i_cfg_wen              | i_cfg_index, i_cfg_wdata
//
// One tick is taken per cycle while the output is not stalled; each sample passes the
// sine table read, the multiply, and the truncate and saturate into the output register.
// The accumulator add is the only loop and closes in the accept cycle.
// Reset (synchronous, active low) clears the accumulator, configuration registers and valid bits.
// When a finished sample is not taken, all three stages hold and o_s_tready drops.
module multi_shape_tone_oscillator
    import mst_pkg::*;
#(
    parameter int PHASE_BITS      = 32,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_BITS     = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input stream.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [7:0]                        i_s_tdata,   // [0] note_start
    // Output stream.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]  o_m_tdata,   // [SAMPLE_BITS-1:0] sample_out
    // Configuration writes.
    input  logic                              i_cfg_wen,
    input  logic [1:0]                        i_cfg_index,
    input  logic [CFG_W-1:0]                  i_cfg_wdata
);

    localparam int OUT_W      = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ALIGN_UP   = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
    localparam int ALIGN_DOWN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam int EXT_W      = PHASE_BITS + 32;
    localparam int ADDR_W     = SINE_TABLE_BITS + 1;
    localparam int QW         = (SAMPLE_BITS > 17) ? SAMPLE_BITS + 1 : 18;
    localparam logic signed [QW-1:0] SAT_HI = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [QW-1:0] SAT_LO = -SAT_HI - QW'(1);

    // Configuration registers.
    logic [SHAPE_W-1:0]  r_wave_shape;
    logic [STEP_W-1:0]   r_phase_step;
    logic [OFFSET_W-1:0] r_phase_offset;
    logic [GAIN_W-1:0]   r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_shape   <= '0;
            r_phase_step   <= '0;
            r_phase_offset <= '0;
            r_gain         <= '0;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_index)
                CFG_WAVE_SHAPE:   r_wave_shape   <= i_cfg_wdata[SHAPE_W-1:0];
                CFG_PHASE_STEP:   r_phase_step   <= i_cfg_wdata[STEP_W-1:0];
                CFG_PHASE_OFFSET: r_phase_offset <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_GAIN:         r_gain         <= i_cfg_wdata[GAIN_W-1:0];
            endcase
        end
    end

    // Align the 31-bit step and 32-bit offset fraction registers to the accumulator width.
    logic [EXT_W-1:0]      w_step_ext;
    logic [EXT_W-1:0]      w_offset_ext;
    logic [PHASE_BITS-1:0] w_step_al;
    logic [PHASE_BITS-1:0] w_offset_al;

    assign w_step_ext   = ((EXT_W'(r_phase_step)) << ALIGN_UP) >> ALIGN_DOWN;
    assign w_offset_ext = ((EXT_W'(r_phase_offset)) << ALIGN_UP) >> ALIGN_DOWN;
    assign w_step_al    = w_step_ext[PHASE_BITS-1:0];
    assign w_offset_al  = w_offset_ext[PHASE_BITS-1:0];

    // Pipeline advance: every stage moves unless a finished sample waits.
    logic r_out_valid;
    logic w_en;
    logic w_accept;

    assign w_en       = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && w_en;
    assign o_s_tready = w_en;

    // Accumulator: load the offset at a note start, then advance after the sample.
    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [PHASE_BITS-1:0] n_phase_acc;
    logic [PHASE_BITS-1:0] w_phase_cur;

    assign w_phase_cur = i_s_tdata[0] ? w_offset_al : r_phase_acc;
    assign n_phase_acc = w_phase_cur + w_step_al;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_acc <= '0;
        end else if (w_accept) begin
            r_phase_acc <= n_phase_acc;
        end
    end

    // Quarter-wave address: mirror the index in the odd quadrants.
    logic [1:0]                 w_quad;
    logic [SINE_TABLE_BITS-1:0] w_idx;
    logic [ADDR_W-1:0]          w_rom_addr;
    logic [SINE_W-1:0]          w_rom_data;

    assign w_quad     = w_phase_cur[PHASE_BITS-1 -: 2];
    assign w_idx      = w_phase_cur[PHASE_BITS-3 -: SINE_TABLE_BITS];
    assign w_rom_addr = w_quad[0] ? (ADDR_W'(1 << SINE_TABLE_BITS) - {1'b0, w_idx})
                                  : {1'b0, w_idx};

    mst_sine_rom #(
        .TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // Stage 1: top 16 phase bits beside the table read.
    logic        r_s1_valid;
    logic [15:0] r_u;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_en) begin
            r_s1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u <= w_phase_cur[PHASE_BITS-1 -: 16];
        end
    end

    // Wave shaping in Q1.15.
    logic signed [WAVE_W-1:0] w_sine;
    logic signed [WAVE_W-1:0] w_square;
    logic signed [WAVE_W-1:0] w_tri;
    logic signed [WAVE_W-1:0] w_saw;
    logic signed [WAVE_W-1:0] w_wave;
    logic [15:0]              w_tri_mag;
    logic [15:0]              w_sine_mag;

    assign w_sine_mag = {1'b0, w_rom_data};
    assign w_sine     = r_u[15] ? -$signed(w_sine_mag) : $signed(w_sine_mag);
    assign w_square   = r_u[15] ? -WAVE_FULL : WAVE_FULL;
    assign w_saw      = $signed({~r_u[15], r_u[14:0]});
    // Distance from mid-cycle; only a phase of zero reaches full distance.
    assign w_tri_mag  = r_u[15] ? {1'b0, r_u[14:0]} : (16'd32768 - r_u);
    assign w_tri      = (r_u == 16'd0) ? WAVE_FULL
                                       : $signed({w_tri_mag[14:0], 1'b0} - 16'd32768);

    always_comb begin
        unique case (r_wave_shape)
            SHAPE_SINE:     w_wave = w_sine;
            SHAPE_SQUARE:   w_wave = w_square;
            SHAPE_TRIANGLE: w_wave = w_tri;
            SHAPE_SAWTOOTH: w_wave = w_saw;
        endcase
    end

    // Stage 2: gain product.
    logic               r_s2_valid;
    logic signed [31:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= w_wave * $signed({1'b0, r_gain});
        end
    end

    // Truncate toward zero by 2^15, then saturate to the sample width.
    logic signed [31:0] w_biased;
    logic signed [31:0] w_shifted;
    logic signed [QW-1:0] w_q;
    logic signed [QW-1:0] w_sat;

    assign w_biased  = r_prod + (r_prod[31] ? 32'sd32767 : 32'sd0);
    assign w_shifted = w_biased >>> 15;
    assign w_q       = w_shifted[QW-1:0];

    always_comb begin
        priority if (w_q > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_q < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_q;
        end
    end

    // Output register.
    logic [SAMPLE_BITS-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= w_sat[SAMPLE_BITS-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out_data);

endmodule

/* rtl/core/mst_checker.sv */
// Port-level checks for the multi-shape tone oscillator, bound to the top level.
// Depends only on the top level's ports.
module mst_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]  o_m_tdata
);

    // A sample that is not taken stays on the bus unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output sample changed while stalled");

    // With no sample waiting, the input side is always open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with an empty output register");

    // Reset leaves no sample on the output.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // A tick taken while the output drains yields a sample after stage 1, stage 2 and the output register.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_m_tready) ##1 i_m_tready ##1 i_m_tready
        |=> o_m_tvalid)
        else $error("sample missing three cycles after its tick");

endmodule

bind multi_shape_tone_oscillator mst_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mst_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

/* tb/tb_multi_shape_tone_oscillator.sv */
// Self-checking testbench for the multi-shape tone oscillator: directed table, then random phases.
// Predicts every sample from its own phase accumulator and sine table and checks each transfer.
// Depends on mst_pkg and the multi_shape_tone_oscillator RTL.
module tb_multi_shape_tone_oscillator;
    import mst_pkg::*;

    localparam int QUARTER_LEN  = 1024;
    localparam int RANDOM_ITEMS = 1600;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 800000;

    // One row of the directed table. Register words are raw, upper bits may be set on purpose.
    typedef struct packed {
        logic               cfg;
        logic [31:0]        shape_w;
        logic [31:0]        step_w;
        logic [31:0]        offset_w;
        logic [31:0]        gain_w;
        logic               note;
        logic               lit_ok;
        logic signed [15:0] lit;
    } t_tone_row;

    localparam int N_ROWS = 24;
    t_tone_row directed_rows [N_ROWS] = '{
        // Reset state: zero gain gives silence, with and without a note start.
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b1, 16'sd0},
        // Full-scale square, both halves of the cycle; zero step holds the phase.
        '{1'b1, 32'(SHAPE_SQUARE), 32'd0, 32'd0, 32'd32767, 1'b1, 1'b1, 16'sd32766},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b1, 16'sd32766},
        '{1'b1, 32'(SHAPE_SQUARE), 32'd0, 32'h8000_0000, 32'd32767, 1'b1, 1'b1, -16'sd32766},
        // Sawtooth at its bottom and top.
        '{1'b1, 32'(SHAPE_SAWTOOTH), 32'd0, 32'd0, 32'd32767, 1'b1, 1'b1, -16'sd32767},
        '{1'b1, 32'(SHAPE_SAWTOOTH), 32'd0, 32'hFFFF_0000, 32'd32767, 1'b1, 1'b1, 16'sd32766},
        // Triangle starts saturated at +1 and reaches -1 at half cycle.
        '{1'b1, 32'(SHAPE_TRIANGLE), 32'd0, 32'd0, 32'd32767, 1'b1, 1'b1, 16'sd32766},
        '{1'b1, 32'(SHAPE_TRIANGLE), 32'd0, 32'h8000_0000, 32'd32767, 1'b1, 1'b1, -16'sd32767},
        // Sine at zero phase, then quarter-cycle steps through all four quadrants.
        '{1'b1, 32'(SHAPE_SINE), 32'd0, 32'd0, 32'd32767, 1'b1, 1'b1, 16'sd0},
        '{1'b1, 32'(SHAPE_SINE), 32'h4000_0000, 32'd0, 32'd32767, 1'b1, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
        // All-ones step, offset and gain words: step and gain are masked, the offset wraps the accumulator.
        '{1'b1, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
        // Out-of-width bits on the shape, step and gain registers, unit gain.
        '{1'b1, 32'hFFFF_FFFD, 32'h8000_0001, 32'h7FFF_FFFF, 32'h0000_8001, 1'b1, 1'b0, 16'sd0},
        '{1'b1, 32'(SHAPE_SAWTOOTH), 32'h0001_0000, 32'd0, 32'd1, 1'b1, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
        // A note restarted in the middle of a running tone.
        '{1'b1, 32'(SHAPE_TRIANGLE), 32'h0123_4567, 32'h89AB_CDEF, 32'd12345, 1'b1, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1, 1'b0, 16'sd0},
        '{1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b0, 1'b0, 16'sd0}
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_s_tvalid  = 1'b0;
    logic             o_s_tready;
    logic [7:0]       i_s_tdata   = 8'd0;   // [0] note_start
    logic             o_m_tvalid;
    logic             i_m_tready  = 1'b0;
    logic [15:0]      o_m_tdata;            // [15:0] sample_out
    logic             i_cfg_wen   = 1'b0;
    logic [1:0]       i_cfg_index = 2'd0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;

    // Predictor state: register copies, phase accumulator and quarter-wave table.
    logic [1:0]  shape_q   = '0;
    logic [30:0] step_q    = '0;
    logic [31:0] offset_q  = '0;
    logic [14:0] gain_q    = '0;
    logic [31:0] phase_acc = '0;
    int          sine_quarter [0:QUARTER_LEN];

    logic signed [15:0] expected_samples [$];
    int                 mismatches  = 0;
    int                 cycle_count = 0;
    bit                 burst_mode  = 1'b0;
    bit                 hold_req    = 1'b0;

    multi_shape_tone_oscillator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_multi_shape_tone_oscillator failed");
            $finish;
        end
    end

    // Quarter-wave sine table from a Q30 Taylor series, rounded to Q1.15.
    function automatic void build_sine_quarter();
        longint unsigned theta;
        longint unsigned t2;
        longint unsigned term;
        longint          sum;
        longint          v;
        for (int k = 0; k <= QUARTER_LEN; k++) begin
            theta = (64'd1686629713 * longint'(k)) >> 10;
            t2    = (theta * theta) >> 30;
            term  = theta;
            sum   = longint'(theta);
            for (int n = 1; n <= 7; n++) begin
                term = ((term * t2) >> 30) / longint'((2 * n) * (2 * n + 1));
                sum  = (n % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
            end
            if (sum < 0) begin
                sum = 0;
            end
            v = (sum * 32767 + (64'sd1 <<< 29)) >>> 30;
            sine_quarter[k] = (v > 32767) ? 32767 : int'(v);
        end
    endfunction

    // Q1.15 wave value for a phase under the current shape.
    function automatic int wave_at(logic [31:0] ph);
        int          u;
        int          a;
        int          w;
        logic [10:0] idx;
        u = int'(ph[31:16]);
        case (shape_q)
            SHAPE_SINE: begin
                idx = {1'b0, ph[29:20]};
                if (ph[30]) begin
                    idx = 11'd1024 - idx;
                end
                w = sine_quarter[idx];
                return ph[31] ? -w : w;
            end
            SHAPE_SQUARE: begin
                return ph[31] ? -32767 : 32767;
            end
            SHAPE_TRIANGLE: begin
                a = u - 32768;
                if (a < 0) begin
                    a = -a;
                end
                w = 2 * a - 32768;
                return (w > 32767) ? 32767 : w;
            end
            default: begin
                return u - 32768;
            end
        endcase
    endfunction

    // One tick: optional restart, scaled sample, then the accumulator advance.
    function automatic logic signed [15:0] tone_next_sample(logic note);
        int p;
        int q;
        if (note) begin
            phase_acc = offset_q;
        end
        p = wave_at(phase_acc) * int'(gain_q);
        q = (p < 0) ? -((-p) >>> 15) : (p >>> 15);
        if (q > 32767) begin
            q = 32767;
        end
        if (q < -32768) begin
            q = -32768;
        end
        phase_acc = phase_acc + {1'b0, step_q};
        return 16'(q);
    endfunction

    // Gap length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    // Random register word: extremes, small values, full range, sometimes with bits above the width.
    function automatic logic [31:0] pick_word(int width);
        logic [31:0] mask;
        logic [31:0] val;
        int          r;
        mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
        r    = $urandom_range(0, 9);
        val  = $urandom;
        if (r == 0) begin
            val = 32'd0;
        end else if (r == 1) begin
            val = mask;
        end else if (r == 2) begin
            val = $urandom_range(0, 32'h0010_0000);
        end
        if ($urandom_range(0, 3) != 0) begin
            val = val & mask;
        end
        return val;
    endfunction

    // Offers one tick and waits for its transfer; the prediction is queued at acceptance.
    task automatic send_tick(input logic note, input logic lit_ok, input logic signed [15:0] lit);
        logic signed [15:0] sample;
        int                 gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {7'd0, note};
        do @(posedge i_clk); while (!o_s_tready);
        sample = tone_next_sample(note);
        expected_samples.push_back(lit_ok ? lit : sample);
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted sample has been taken.
    task automatic drain_samples();
        i_s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Writes all four registers on consecutive edges and updates the predictor copies.
    task automatic program_tone(input logic [31:0] shape_w, input logic [31:0] step_w,
                                input logic [31:0] offset_w, input logic [31:0] gain_w);
        i_cfg_wen   <= 1'b1;
        i_cfg_index <= CFG_WAVE_SHAPE;
        i_cfg_wdata <= shape_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_PHASE_STEP;
        i_cfg_wdata <= step_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_PHASE_OFFSET;
        i_cfg_wdata <= offset_w;
        @(posedge i_clk);
        i_cfg_index <= CFG_GAIN;
        i_cfg_wdata <= gain_w;
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        shape_q  = shape_w[1:0];
        step_q   = step_w[30:0];
        offset_q = offset_w;
        gain_q   = gain_w[14:0];
    endtask

    // Output side: check each transfer, then choose the next ready with stalls and long holds.
    initial begin
        int                 stall_left;
        int                 hold_left;
        int                 gap;
        logic signed [15:0] want;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample_out: no sample expected, got %0d", $signed(o_m_tdata));
                    mismatches++;
                end else begin
                    want = expected_samples.pop_front();
                    if ($signed(o_m_tdata) !== want) begin
                        $error("sample_out: expected %0d, got %0d", want, $signed(o_m_tdata));
                        mismatches++;
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!burst_mode && $urandom_range(0, 3) == 0) begin
                gap = pick_gap();
                stall_left = (gap > 0) ? gap - 1 : 0;
                i_m_tready <= (gap == 0);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Input side: reset, directed table, random phases, final drain.
    initial begin
        int   sent;
        int   phase_len;
        int   phase_idx;
        logic note;
        build_sine_quarter();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table; register changes only while nothing is in flight.
        for (int i = 0; i < N_ROWS; i++) begin
            if (directed_rows[i].cfg) begin
                drain_samples();
                program_tone(directed_rows[i].shape_w, directed_rows[i].step_w,
                             directed_rows[i].offset_w, directed_rows[i].gain_w);
            end
            send_tick(directed_rows[i].note, directed_rows[i].lit_ok, directed_rows[i].lit);
        end

        // Random phases: a fresh setting, usually a note start, then mostly running ticks.
        sent      = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_samples();
            program_tone(pick_word(SHAPE_W), pick_word(STEP_W), pick_word(OFFSET_W),
                         pick_word(GAIN_W));
            burst_mode = ($urandom_range(0, 4) == 0);
            if (phase_idx == 2) begin
                burst_mode = 1'b1;
                hold_req   = 1'b1;
            end
            phase_len = $urandom_range(20, 150);
            for (int j = 0; j < phase_len; j++) begin
                note = (j == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 11) == 0);
                send_tick(note, 1'b0, 16'sd0);
                sent++;
            end
            phase_idx++;
        end

        drain_samples();
        burst_mode = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("tb_multi_shape_tone_oscillator passed");
        end else begin
            $display("tb_multi_shape_tone_oscillator failed");
        end
        $finish;
    end

endmodule
